// ===== src/psk_pkg.sv =====
// Shared types and constants for the paired sorted key table.
// No dependencies.
package psk_pkg;
  localparam int unsigned CapacityDefault = 1024;
  localparam int unsigned KeyBitsDefault  = 32;
  localparam int unsigned PosBits         = 10;
  localparam int unsigned PortKeyBits     = 32;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_LOOKUP = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SHIFT_RD,
    BK_SHIFT_WR,
    BK_SEARCH_RD,
    BK_SEARCH_CMP,
    BK_FINAL_RD,
    BK_FINAL_CMP,
    BK_EMIT
  } back_state_e;

  // Command handed from front to back.
  typedef struct packed {
    action_e           action;
    logic [PortKeyBits-1:0] left_key;
    logic [PortKeyBits-1:0] right_key;
    logic              query_side;
    logic [PortKeyBits-1:0] query_key;
  } cmd_t;

  typedef struct packed {
    status_e           status;
    logic [PortKeyBits-1:0] linked_key;
    logic [PosBits-1:0] position;
  } rsp_t;
endpackage

// ===== src/psk_front.sv =====
// Front end: accept items into a two-entry command queue.
// Depends on psk_pkg.
module psk_front import psk_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  output logic full_o,
  input  cmd_t cmd_i,
  output logic cmd_valid_o,
  input  logic cmd_take_i,
  output cmd_t cmd_o
);
  cmd_t       buf_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign full_o      = cnt_q == 2'd2;
  assign cmd_valid_o = cnt_q != 2'd0;
  assign cmd_o       = buf_q[rp_q];
  assign wr = push_i && !full_o;
  assign rd = cmd_take_i && cmd_valid_o;

  always_ff @(posedge clk_i) begin
    if (wr) buf_q[wp_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end
endmodule

// ===== src/psk_back.sv =====
// Back end: table memories, insertion shift and binary search sequencer.
// Depends on psk_pkg.
module psk_back import psk_pkg::*; #(
  parameter int unsigned Capacity = CapacityDefault,
  parameter int unsigned KeyBits  = KeyBitsDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  output logic cmd_take_o,
  input  cmd_t cmd_i,
  output logic rsp_valid_o,
  input  logic rsp_take_i,
  output rsp_t rsp_o
);
  localparam int unsigned AW = $clog2(Capacity);
  localparam int unsigned CW = $clog2(Capacity + 1);
  typedef logic [KeyBits-1:0] key_t;

  // Entry word: {key, link} for each side.
  logic [2*KeyBits-1:0] lmem [Capacity];
  logic [2*KeyBits-1:0] rmem [Capacity];

  back_state_e st_q, st_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] p_q, p_d, lo_q, lo_d, hi_q, hi_d;
  logic          ldone_q, ldone_d, rdone_q, rdone_d;
  cmd_t          cmd_q;
  logic          load_cmd;
  rsp_t          rsp_q, rsp_d;
  rsp_t          res_q, res_d;
  logic          rv_q, rv_d;
  logic [2*KeyBits-1:0] lrd_q, rrd_q;
  logic [AW-1:0] raddr;
  logic          lwe, rwe;
  logic [AW-1:0] lwa, rwa;
  logic [2*KeyBits-1:0] lwd, rwd;
  key_t lk, rk, qk, sk, slink;
  logic [CW-1:0] mid;

  assign lk = key_t'(cmd_q.left_key);
  assign rk = key_t'(cmd_q.right_key);
  assign qk = key_t'(cmd_q.query_key);
  assign sk    = cmd_q.query_side ? rrd_q[2*KeyBits-1:KeyBits] : lrd_q[2*KeyBits-1:KeyBits];
  assign slink = cmd_q.query_side ? rrd_q[KeyBits-1:0] : lrd_q[KeyBits-1:0];
  assign mid   = lo_q + ((hi_q - lo_q) >> 1);

  always_ff @(posedge clk_i) begin
    if (lwe) lmem[lwa] <= lwd;
    if (rwe) rmem[rwa] <= rwd;
    lrd_q <= lmem[raddr];
    rrd_q <= rmem[raddr];
    if (load_cmd) cmd_q <= cmd_i;
    rsp_q <= rsp_d;
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= BK_IDLE; cnt_q <= '0; rv_q <= 1'b0;
      p_q <= '0; lo_q <= '0; hi_q <= '0; ldone_q <= 1'b0; rdone_q <= 1'b0;
    end else begin
      st_q <= st_d; cnt_q <= cnt_d; rv_q <= rv_d;
      p_q <= p_d; lo_q <= lo_d; hi_q <= hi_d; ldone_q <= ldone_d; rdone_q <= rdone_d;
    end
  end

  assign rsp_valid_o = rv_q;
  assign rsp_o       = rsp_q;

  always_comb begin
    logic [CW-1:0] pm1;
    logic lmove, rmove;
    pm1 = p_q - 1'b1;
    st_d = st_q; cnt_d = cnt_q; rv_d = rv_q; rsp_d = rsp_q; res_d = res_q;
    p_d = p_q; lo_d = lo_q; hi_d = hi_q; ldone_d = ldone_q; rdone_d = rdone_q;
    load_cmd = 1'b0; cmd_take_o = 1'b0;
    raddr = AW'(pm1);
    lwe = 1'b0; rwe = 1'b0; lwa = AW'(p_q); rwa = AW'(p_q);
    lwd = {lk, rk}; rwd = {rk, lk};
    lmove = 1'b0; rmove = 1'b0;
    if (rv_q && rsp_take_i) rv_d = 1'b0;
    unique case (st_q)
      BK_IDLE: begin
        if (cmd_valid_i) begin
          cmd_take_o = 1'b1; load_cmd = 1'b1;
          unique case (cmd_i.action)
            ACT_INSERT: begin
              if (cnt_q >= CW'(Capacity)) begin
                res_d = '{ST_FULL, '0, '0}; st_d = BK_EMIT;
              end else begin
                p_d = cnt_q; ldone_d = 1'b0; rdone_d = 1'b0; st_d = BK_SHIFT_RD;
              end
            end
            ACT_LOOKUP: begin
              lo_d = '0; hi_d = cnt_q; st_d = BK_SEARCH_RD;
            end
            ACT_CLEAR: begin
              cnt_d = '0; res_d = '{ST_OK, '0, '0}; st_d = BK_EMIT;
            end
            default: begin
              res_d = '{ST_OK, '0, '0}; st_d = BK_EMIT;
            end
          endcase
        end
      end
      BK_SHIFT_RD: begin
        // Read entry p-1 of both tables.
        if (p_q == '0) begin
          lwe = !ldone_q; rwe = !rdone_q;
          cnt_d = cnt_q + 1'b1; res_d = '{ST_OK, '0, '0}; st_d = BK_EMIT;
        end else begin
          st_d = BK_SHIFT_WR;
        end
      end
      BK_SHIFT_WR: begin
        lmove = !ldone_q && (lrd_q[2*KeyBits-1:KeyBits] > lk);
        rmove = !rdone_q && (rrd_q[2*KeyBits-1:KeyBits] > rk);
        // Move larger entries up; drop the new entry once its slot is found.
        lwe = !ldone_q; rwe = !rdone_q;
        lwd = lmove ? lrd_q : {lk, rk};
        rwd = rmove ? rrd_q : {rk, lk};
        ldone_d = ldone_q || !lmove;
        rdone_d = rdone_q || !rmove;
        if (!lmove && !rmove) begin
          cnt_d = cnt_q + 1'b1; res_d = '{ST_OK, '0, '0}; st_d = BK_EMIT;
        end else begin
          p_d = pm1; st_d = BK_SHIFT_RD;
        end
      end
      BK_SEARCH_RD: begin
        raddr = AW'(mid);
        st_d = (lo_q < hi_q) ? BK_SEARCH_CMP : BK_FINAL_RD;
        if (!(lo_q < hi_q)) raddr = AW'(lo_q);
      end
      BK_SEARCH_CMP: begin
        if (sk < qk) lo_d = mid + 1'b1;
        else hi_d = mid;
        st_d = BK_SEARCH_RD;
      end
      BK_FINAL_RD: st_d = BK_FINAL_CMP;
      BK_FINAL_CMP: begin
        // Read data for lo was held since the search ended.
        if (lo_q < cnt_q && sk == qk)
          res_d = '{ST_OK, PortKeyBits'(slink), PosBits'(lo_q)};
        else
          res_d = '{ST_NOT_FOUND, '0, '0};
        st_d = BK_EMIT;
      end
      BK_EMIT: begin
        // Hold the finished result until the output register is free.
        if (!rv_q || rsp_take_i) begin
          rsp_d = res_q; rv_d = 1'b1; st_d = BK_IDLE;
        end
      end
      default: st_d = BK_IDLE;
    endcase
    if (st_q == BK_FINAL_RD) raddr = AW'(lo_q);
  end
endmodule

// ===== src/paired_sorted_key_table.sv =====
// Top level of the paired sorted key table.
// Depends on psk_pkg, psk_front and psk_back.
//
// Two sorted tables of keys, each entry linked to its partner key. Push an
// item (insert pair, lookup, clear); pop one result per item in order. An
// insert moves up every stored key larger than the new one on each side,
// one entry per shift step; each shift step reads the table memory and then
// writes it. A lookup is a binary search with one memory read per search
// step. Clear and refused inserts go straight to the result. A two-entry
// queue takes new items while the back end works, and a result register
// holds a finished result until popped. No clearing pass.
module paired_sorted_key_table import psk_pkg::*; #(
  parameter int unsigned Capacity = CapacityDefault,
  parameter int unsigned KeyBits  = KeyBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  action_i,
  input  logic [31:0] left_key_i,
  input  logic [31:0] right_key_i,
  input  logic        query_side_i,
  input  logic [31:0] query_key_i,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  status_o,
  output logic [31:0] linked_key_o,
  output logic [9:0]  position_o
);
  cmd_t cmd_in, cmd;
  logic cmd_valid, cmd_take, rsp_valid;
  rsp_t rsp;

  assign cmd_in = '{action_e'(action_i), left_key_i, right_key_i, query_side_i, query_key_i};

  psk_front u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full), .cmd_i(cmd_in),
    .cmd_valid_o(cmd_valid), .cmd_take_i(cmd_take), .cmd_o(cmd)
  );

  psk_back #(.Capacity(Capacity), .KeyBits(KeyBits)) u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_take_o(cmd_take), .cmd_i(cmd),
    .rsp_valid_o(rsp_valid), .rsp_take_i(pop), .rsp_o(rsp)
  );

  assign empty        = !rsp_valid;
  assign status_o     = rsp.status;
  assign linked_key_o = rsp.linked_key;
  assign position_o   = rsp.position;
endmodule
